>>> design/rci_pkg.sv
// shared types, constants and helpers for the ray/cylinder intersection core
package rci_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [30:0] RADIUS_RESET = 31'd65536;

  typedef enum logic [1:0] {
    REG_AXIS_X = 2'd0,
    REG_AXIS_Y = 2'd1,
    REG_RADIUS = 2'd2
  } rci_reg_e;

  // payload alongside the square root pipeline
  typedef struct packed {
    logic               go;
    logic [30:0]        a;
    logic signed [31:0] b;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } rci_sq_pl_t;

  // payload alongside the root dividers
  typedef struct packed {
    logic               go;
    logic               sign0;
    logic               sign1;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } rci_dv_pl_t;

  // payload alongside the normal dividers
  typedef struct packed {
    logic               found;
    logic        [31:0] t;
    logic        [31:0] px;
    logic        [31:0] py;
    logic        [31:0] pz;
    logic               sx;
    logic               sy;
  } rci_nm_pl_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> design/ray_cylinder_intersect_core.sv
// Ray against an infinite z-parallel cylinder: one ray per cycle, hit, t, point and radial
// normal out. Fully pipelined: a new ray is taken every cycle while the output register is
// free or being taken. The pipeline holds the 32-stage square root and two levels of
// restoring dividers of 33 + FRAC_BITS stages each (root division by the quadratic term,
// normal division by the radius). A stalled output holds the whole pipeline. The user must
// write configuration registers only while no ray is in flight; the core does not enforce it.
module ray_cylinder_intersect_core #(
  parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_t, point_x, point_y, point_z, normal_x, normal_y, zero fill
  output logic [199:0] m_axis_tdata,
  // hit
  output logic [0:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  import rci_pkg::*;

  localparam int NW = 33 + FRAC_BITS;

  logic        en;
  logic [31:0] axis_x_q, axis_y_q;
  logic [30:0] radius_q;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q <= '0;
      axis_y_q <= '0;
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite) begin
      case (rci_reg_e'(paddr[3:2]))
        REG_AXIS_X: axis_x_q <= pwdata;
        REG_AXIS_Y: axis_y_q <= pwdata;
        REG_RADIUS: radius_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rci_reg_e'(paddr[3:2]))
      REG_AXIS_X: prdata = axis_x_q;
      REG_AXIS_Y: prdata = axis_y_q;
      REG_RADIUS: prdata = {1'b0, radius_q};
      default:    prdata = '0;
    endcase
  end

  logic signed [31:0] ax_s, ay_s;
  assign ax_s = axis_x_q;
  assign ay_s = axis_y_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: offset from axis
  logic               v1_q;
  logic signed [31:0] org1_q [3];
  logic signed [31:0] dir1_q [3];
  logic signed [31:0] lo1_q, hi1_q, ox1_q, oy1_q;
  logic signed [31:0] in_ox, in_oy;

  assign in_ox = s_axis_tdata[31:0];
  assign in_oy = s_axis_tdata[63:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        org1_q[k] <= s_axis_tdata[32*k +: 32];
        dir1_q[k] <= s_axis_tdata[96 + 32*k +: 32];
      end
      lo1_q <= s_axis_tdata[223:192];
      hi1_q <= s_axis_tdata[255:224];
      ox1_q <= sat32(64'(in_ox) - 64'(ax_s));
      oy1_q <= sat32(64'(in_oy) - 64'(ay_s));
    end
  end

  // stage 2: products
  logic               v2_q;
  logic signed [31:0] org2_q [3];
  logic signed [31:0] dir2_q [3];
  logic signed [31:0] lo2_q, hi2_q;
  logic signed [63:0] dxdx_q, dydy_q, oxdx_q, oydy_q, oxox_q, oyoy_q, rr_q;
  logic        [63:0] rr_u;

  assign rr_u = {1'b0, radius_q} * {1'b0, radius_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      org2_q <= org1_q;
      dir2_q <= dir1_q;
      lo2_q  <= lo1_q;
      hi2_q  <= hi1_q;
      dxdx_q <= dir1_q[0] * dir1_q[0];
      dydy_q <= dir1_q[1] * dir1_q[1];
      oxdx_q <= ox1_q * dir1_q[0];
      oydy_q <= oy1_q * dir1_q[1];
      oxox_q <= ox1_q * ox1_q;
      oyoy_q <= oy1_q * oy1_q;
      rr_q   <= rr_u;
    end
  end

  // stage 3: quadratic terms
  logic               v3_q;
  logic signed [31:0] org3_q [3];
  logic signed [31:0] dir3_q [3];
  logic signed [31:0] lo3_q, hi3_q, b3_q, c3_q;
  logic        [30:0] a3_q;
  logic        [31:0] a_full;

  assign a_full = sat32((dxdx_q >>> FRAC_BITS) + (dydy_q >>> FRAC_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      org3_q <= org2_q;
      dir3_q <= dir2_q;
      lo3_q  <= lo2_q;
      hi3_q  <= hi2_q;
      a3_q   <= a_full[30:0];
      b3_q   <= sat32((oxdx_q >>> FRAC_BITS) + (oydy_q >>> FRAC_BITS));
      c3_q   <= sat32((oxox_q >>> FRAC_BITS) + (oyoy_q >>> FRAC_BITS)
                      - (rr_q >>> FRAC_BITS));
    end
  end

  // stage 4: discriminant products
  logic               v4_q;
  logic signed [31:0] org4_q [3];
  logic signed [31:0] dir4_q [3];
  logic signed [31:0] lo4_q, hi4_q, b4_q;
  logic        [30:0] a4_q;
  logic signed [63:0] bb4_q, ac4_q;
  logic signed [31:0] a3_s;

  assign a3_s = {1'b0, a3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      org4_q <= org3_q;
      dir4_q <= dir3_q;
      lo4_q  <= lo3_q;
      hi4_q  <= hi3_q;
      a4_q   <= a3_q;
      b4_q   <= b3_q;
      bb4_q  <= b3_q * b3_q;
      ac4_q  <= a3_s * c3_q;
    end
  end

  // stage 5: discriminant
  logic               v5_q;
  rci_sq_pl_t         pl5_q;
  logic        [63:0] disc5_q;
  logic signed [64:0] disc;

  assign disc = {bb4_q[63], bb4_q} - {ac4_q[63], ac4_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc5_q     <= disc[63:0];
      pl5_q.go    <= !disc[64] && (disc != '0) && (a4_q != '0);
      pl5_q.a     <= a4_q;
      pl5_q.b     <= b4_q;
      pl5_q.org_x <= org4_q[0];
      pl5_q.org_y <= org4_q[1];
      pl5_q.org_z <= org4_q[2];
      pl5_q.dir_x <= dir4_q[0];
      pl5_q.dir_y <= dir4_q[1];
      pl5_q.dir_z <= dir4_q[2];
      pl5_q.lo    <= lo4_q;
      pl5_q.hi    <= hi4_q;
    end
  end

  // square root
  logic        [31:0] sroot;
  logic               vsq;
  rci_sq_pl_t         plsq;

  rci_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (disc5_q),
    .root_o (sroot)
  );

  rci_delay #(.W($bits(rci_sq_pl_t)), .N(32)) u_dly_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (v5_q),
    .d_i    (pl5_q),
    .v_o    (vsq),
    .d_o    (plsq)
  );

  // stage 6: both root numerators
  logic               v6_q;
  rci_dv_pl_t         pl6_q;
  logic        [30:0] a6_q;
  logic        [32:0] mag0_q, mag1_q;
  logic signed [34:0] nb, num0, num1, neg0, neg1;

  assign nb   = -35'(plsq.b);
  assign num0 = nb - 35'(sroot);
  assign num1 = nb + 35'(sroot);
  assign neg0 = -num0;
  assign neg1 = -num1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= vsq;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a6_q        <= plsq.a;
      mag0_q      <= num0[34] ? neg0[32:0] : num0[32:0];
      mag1_q      <= num1[34] ? neg1[32:0] : num1[32:0];
      pl6_q.go    <= plsq.go;
      pl6_q.sign0 <= num0[34];
      pl6_q.sign1 <= num1[34];
      pl6_q.org_x <= plsq.org_x;
      pl6_q.org_y <= plsq.org_y;
      pl6_q.org_z <= plsq.org_z;
      pl6_q.dir_x <= plsq.dir_x;
      pl6_q.dir_y <= plsq.dir_y;
      pl6_q.dir_z <= plsq.dir_z;
      pl6_q.lo    <= plsq.lo;
      pl6_q.hi    <= plsq.hi;
    end
  end

  // root division
  logic [NW-1:0] q0, q1;
  logic          vdv;
  rci_dv_pl_t    pldv;

  rci_div #(.NW(NW), .DW(31)) u_div_t0 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({mag0_q, {FRAC_BITS{1'b0}}}),
    .den_i (a6_q),
    .quo_o (q0)
  );

  rci_div #(.NW(NW), .DW(31)) u_div_t1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({mag1_q, {FRAC_BITS{1'b0}}}),
    .den_i (a6_q),
    .quo_o (q1)
  );

  rci_delay #(.W($bits(rci_dv_pl_t)), .N(NW)) u_dly_dv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (v6_q),
    .d_i    (pl6_q),
    .v_o    (vdv),
    .d_o    (pldv)
  );

  // stage 7: pick the root
  logic               v7_q, found7_q;
  logic signed [31:0] t7_q;
  logic signed [31:0] org7_q [3];
  logic signed [31:0] dir7_q [3];
  logic signed [NW:0] cand0, cand1, lo_x, hi_x;
  logic               in0, in1;

  assign cand0 = pldv.sign0 ? -{1'b0, q0} : {1'b0, q0};
  assign cand1 = pldv.sign1 ? -{1'b0, q1} : {1'b0, q1};
  assign lo_x  = (NW+1)'(pldv.lo);
  assign hi_x  = (NW+1)'(pldv.hi);
  assign in0   = (cand0 > lo_x) && (cand0 < hi_x);
  assign in1   = (cand1 > lo_x) && (cand1 < hi_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q     <= 1'b0;
      found7_q <= 1'b0;
    end else if (en) begin
      v7_q     <= vdv;
      found7_q <= vdv && pldv.go && (in0 || in1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t7_q      <= in0 ? cand0[31:0] : cand1[31:0];
      org7_q[0] <= pldv.org_x;
      org7_q[1] <= pldv.org_y;
      org7_q[2] <= pldv.org_z;
      dir7_q[0] <= pldv.dir_x;
      dir7_q[1] <= pldv.dir_y;
      dir7_q[2] <= pldv.dir_z;
    end
  end

  // stage 8: t times direction
  logic               v8_q, found8_q;
  logic signed [31:0] t8_q;
  logic signed [31:0] org8_q [3];
  logic signed [63:0] td8_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q     <= 1'b0;
      found8_q <= 1'b0;
    end else if (en) begin
      v8_q     <= v7_q;
      found8_q <= found7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t8_q   <= t7_q;
      org8_q <= org7_q;
      for (int k = 0; k < 3; k++) td8_q[k] <= t7_q * dir7_q[k];
    end
  end

  // stage 9: hit point
  logic               v9_q, found9_q;
  logic signed [31:0] t9_q;
  logic signed [31:0] p9_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q     <= 1'b0;
      found9_q <= 1'b0;
    end else if (en) begin
      v9_q     <= v8_q;
      found9_q <= found8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t9_q <= t8_q;
      for (int k = 0; k < 3; k++) begin
        p9_q[k] <= sat32(64'(org8_q[k]) + (td8_q[k] >>> FRAC_BITS));
      end
    end
  end

  // stage 10: offset of the point from the axis
  logic               v10_q;
  rci_nm_pl_t         pl10_q;
  logic        [32:0] magx_q, magy_q;
  logic signed [32:0] dfx, dfy, ndfx, ndfy;

  assign dfx  = 33'(p9_q[0]) - 33'(ax_s);
  assign dfy  = 33'(p9_q[1]) - 33'(ay_s);
  assign ndfx = -dfx;
  assign ndfy = -dfy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else if (en) v10_q <= v9_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      magx_q       <= dfx[32] ? ndfx : dfx;
      magy_q       <= dfy[32] ? ndfy : dfy;
      pl10_q.found <= found9_q;
      pl10_q.t     <= t9_q;
      pl10_q.px    <= p9_q[0];
      pl10_q.py    <= p9_q[1];
      pl10_q.pz    <= p9_q[2];
      pl10_q.sx    <= dfx[32];
      pl10_q.sy    <= dfy[32];
    end
  end

  // normal division
  logic [NW-1:0] qx, qy;
  logic          vnm;
  rci_nm_pl_t    plnm;

  rci_div #(.NW(NW), .DW(31)) u_div_nx (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({magx_q, {FRAC_BITS{1'b0}}}),
    .den_i (radius_q),
    .quo_o (qx)
  );

  rci_div #(.NW(NW), .DW(31)) u_div_ny (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({magy_q, {FRAC_BITS{1'b0}}}),
    .den_i (radius_q),
    .quo_o (qy)
  );

  rci_delay #(.W($bits(rci_nm_pl_t)), .N(NW)) u_dly_nm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (v10_q),
    .d_i    (pl10_q),
    .v_o    (vnm),
    .d_o    (plnm)
  );

  // output register
  logic [NW-1:0] lim_pos, lim_neg;
  logic [31:0]   nx, ny, nqx, nqy;
  logic          out_v_q;
  logic          hit_q;
  logic [199:0]  data_q;

  assign lim_pos = {{(NW-32){1'b0}}, 32'h7fff_ffff};
  assign lim_neg = {{(NW-32){1'b0}}, 32'h8000_0000};
  assign nqx     = -qx[31:0];
  assign nqy     = -qy[31:0];

  always_comb begin
    if (radius_q == '0) begin
      nx = '0;
    end else if (plnm.sx) begin
      nx = (qx > lim_neg) ? 32'h8000_0000 : nqx;
    end else begin
      nx = (qx > lim_pos) ? 32'h7fff_ffff : qx[31:0];
    end
    if (radius_q == '0) begin
      ny = '0;
    end else if (plnm.sy) begin
      ny = (qy > lim_neg) ? 32'h8000_0000 : nqy;
    end else begin
      ny = (qy > lim_pos) ? 32'h7fff_ffff : qy[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= vnm;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= plnm.found;
      if (plnm.found) begin
        data_q <= {8'd0, ny, nx, plnm.pz, plnm.py, plnm.px, plnm.t};
      end else begin
        data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tuser[0] = hit_q;
  assign m_axis_tdata    = data_q;

  // a miss carries an all-zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss transfer with nonzero payload");

  // zero radius forces zero normals
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (radius_q == '0) |-> m_axis_tdata[191:128] == '0)
    else $error("nonzero normal with zero radius");

  // a root is only selected on an occupied slot
  a_found_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found7_q |-> v7_q)
    else $error("root selected in an empty slot");

endmodule

>>> design/rci_delay.sv
// delay line with a reset valid lane and an enable
module rci_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         v_i,
  input  logic [W-1:0] d_i,
  output logic         v_o,
  output logic [W-1:0] d_o
);

  logic         v_q [N];
  logic [W-1:0] d_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= v_i;
      for (int k = 1; k < N; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= d_i;
      for (int k = 1; k < N; k++) d_q[k] <= d_q[k-1];
    end
  end

  assign v_o = v_q[N-1];
  assign d_o = d_q[N-1];

endmodule

>>> design/rci_isqrt.sv
// pipelined floor square root, 64 bit radicand, one result bit per stage
module rci_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  localparam int NS = 32;

  logic [63:0] rad_q  [NS];
  logic [35:0] rem_q  [NS];
  logic [31:0] root_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [63:0] rad_in;
    logic [35:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[33:0], rad_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[61:0], 2'b00};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[30:0], ge};
      end
    end
  end

  assign root_o = root_q[NS-1];

endmodule

>>> design/rci_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module rci_div #(
  parameter int NW = 49,
  parameter int DW = 31
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign sh   = {rem_in, nq_in[NW-1]};
    assign ge   = sh >= {1'b0, den_in};
    assign diff = sh - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        rem_q[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

>>> tb/ray_cylinder_intersect_core_tb.sv
// testbench for the ray/cylinder intersection core: random and corner rays checked against a predictor
`timescale 1ns / 1ps

class ray_hit_board;
  typedef struct {
    logic [0:0]   hit;
    logic [199:0] data;
  } hit_rec_t;

  hit_rec_t          pending[$];
  logic signed [31:0] axis_x = 0;
  logic signed [31:0] axis_y = 0;
  logic        [30:0] radius = 31'd65536;
  int                 errors = 0;

  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fshr(longint x);
    return x >>> 16;
  endfunction

  function automatic longint root_floor(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void note_ray(logic [255:0] ray);
    longint org[3], dir[3], lo, hi, ax, ay, r, ox, oy, a, b, c, disc, s, num, cand, t;
    longint px, py, pz, nx, ny;
    hit_rec_t rec;
    bit found;
    for (int k = 0; k < 3; k++) begin
      org[k] = longint'($signed(ray[32*k +: 32]));
      dir[k] = longint'($signed(ray[32*(k+3) +: 32]));
    end
    lo = longint'($signed(ray[192 +: 32]));
    hi = longint'($signed(ray[224 +: 32]));
    ax = longint'(axis_x);
    ay = longint'(axis_y);
    r = longint'({1'b0, radius});
    rec.hit = 0;
    rec.data = '0;
    found = 0;
    t = 0;
    ox = sat(org[0] - ax);
    oy = sat(org[1] - ay);
    a = sat(fshr(dir[0] * dir[0]) + fshr(dir[1] * dir[1]));
    b = sat(fshr(ox * dir[0]) + fshr(oy * dir[1]));
    c = sat(fshr(ox * ox) + fshr(oy * oy) - fshr(r * r));
    disc = b * b - a * c;
    if (disc > 0 && a > 0) begin
      s = root_floor(disc);
      for (int k = 0; k < 2 && !found; k++) begin
        num = (k == 0) ? (-b - s) : (-b + s);
        cand = (num * 65536) / a;
        if (cand > lo && cand < hi) begin
          t = cand;
          found = 1;
        end
      end
    end
    if (found) begin
      px = sat(org[0] + fshr(t * dir[0]));
      py = sat(org[1] + fshr(t * dir[1]));
      pz = sat(org[2] + fshr(t * dir[2]));
      nx = 0;
      ny = 0;
      if (r != 0) begin
        nx = sat(((px - ax) * 65536) / r);
        ny = sat(((py - ay) * 65536) / r);
      end
      rec.hit = 1;
      rec.data = {1'b0, 32'(ny), 32'(nx), 32'(pz), 32'(py), 32'(px), 32'(t)};
    end
    pending.push_back(rec);
  endfunction

  function automatic void check_hit(logic [0:0] hit, logic [199:0] data);
    hit_rec_t exp_rec;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result hit=%0d data=%h", hit, data);
      return;
    end
    exp_rec = pending.pop_front();
    if (hit !== exp_rec.hit || data !== exp_rec.data) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp hit=%0d data=%h, got hit=%0d data=%h",
                 exp_rec.hit, exp_rec.data, hit, data);
    end
  endfunction
endclass

module ray_cylinder_intersect_core_tb;
  import rci_pkg::*;

  localparam int LATENCY = 141;
  localparam int STALL_LIMIT = 20000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [199:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  ray_hit_board board;
  int           idle_cycles = 0;

  ray_cylinder_intersect_core dut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(rci_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = 4'(idx) << 2;
    pwdata = value;
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0;
    penable = 0;
    pwrite = 0;
    case (idx)
      REG_AXIS_X: board.axis_x = value;
      REG_AXIS_Y: board.axis_y = value;
      default:    board.radius = value[30:0];
    endcase
  endtask

  task automatic send_ray(logic [255:0] ray);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    s_axis_tdata = ray;
    s_axis_tvalid = 1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_ray(ray);
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [255:0] pack_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                            int lo, int hi);
    return {32'(hi), 32'(lo), 32'(dz), 32'(dy), 32'(dx), 32'(oz), 32'(oy), 32'(ox)};
  endfunction

  function automatic logic [255:0] aimed_ray(int rad);
    int ox, oy, dx, dy;
    ox = $signed($urandom_range(0, 12 * rad)) - 6 * rad;
    oy = $signed($urandom_range(0, 12 * rad)) - 6 * rad;
    dx = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
    dy = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
    if ($urandom_range(0, 1)) begin
      dx = -ox / 4 + $signed($urandom_range(0, 1 << 14)) - (1 << 13);
      dy = -oy / 4 + $signed($urandom_range(0, 1 << 14)) - (1 << 13);
    end
    return pack_ray(ox + int'(board.axis_x), oy + int'(board.axis_y), $urandom(), dx, dy,
                    $urandom(), $signed($urandom_range(0, 4 << 16)) - (3 << 16),
                    $urandom_range(0, 1) ? 32'h7fff_ffff : $urandom_range(1 << 16, 64 << 16));
  endfunction

  task automatic random_phase(int n, int rad);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) send_ray(aimed_ray(rad));
      else send_ray({pick_val(), pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
                     pick_val(), pick_val()});
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !rst_ni ? 1'b1 : (($urandom_range(0, 9) < 2) ? 1'b0 : 1'b1);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_hit(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        board.pending.size() == 0 && !s_axis_tvalid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    board = new();
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed rays at reset settings, unit radius
    send_ray(pack_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, 0, 32'h7fff_ffff));
    send_ray(pack_ray(0, 0, 5 << 16, 1 << 16, 0, 7 << 16, 0, 32'h7fff_ffff));
    send_ray(pack_ray(0, 0, 0, 0, 0, 1 << 16, 32'h8000_0000, 32'h7fff_ffff));
    send_ray(pack_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, 5 << 16, 1 << 16));
    send_ray(pack_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, 2 << 16, 2 << 16));
    send_ray(pack_ray(-3 << 16, 0, 0, 1 << 16, 0, 0, 2 << 16, 32'h7fff_ffff));
    send_ray(pack_ray(-3 << 16, 1 << 16, 0, 1 << 16, 0, 0, 0, 32'h7fff_ffff));
    send_ray(pack_ray(-3 << 16, 2 << 16, 0, 1 << 16, 0, 0, 0, 32'h7fff_ffff));
    send_ray(pack_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_ray({8{32'hffff_ffff}});
    send_ray('0);
    send_ray(pack_ray(0, 0, 0, 1 << 16, 1 << 16, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    random_phase(200, 1 << 16);
    drain();

    write_reg(REG_AXIS_X, 3 << 16);
    write_reg(REG_AXIS_Y, -(2 << 16));
    write_reg(REG_RADIUS, 5 << 15);
    random_phase(200, 5 << 15);
    drain();

    write_reg(REG_AXIS_X, 32'h7fff_ffff);
    write_reg(REG_AXIS_Y, 32'h8000_0000);
    write_reg(REG_RADIUS, 32'h7fff_ffff);
    random_phase(120, 1 << 20);
    drain();

    write_reg(REG_AXIS_X, 32'h8000_0000);
    write_reg(REG_AXIS_Y, 32'h7fff_ffff);
    write_reg(REG_RADIUS, 1);
    random_phase(120, 4);
    drain();

    write_reg(REG_RADIUS, 0);
    random_phase(60, 1 << 12);
    drain();

    write_reg(REG_AXIS_X, $urandom_range(0, 1 << 20));
    write_reg(REG_AXIS_Y, $urandom());
    write_reg(REG_RADIUS, $urandom_range(1 << 14, 1 << 18));
    random_phase(340, int'(board.radius));
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
